/* rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define GCCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define GCCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/gccl_pkg.sv */
// types and constants of the grid connected component labeling block
package gccl_pkg;

  localparam int CfgW = 9;
  localparam int LblW = 15;

  localparam logic [LblW-1:0] NO_LABEL  = 15'h7fff;
  localparam logic [LblW-1:0] LABEL_MAX = 15'd16383;
  localparam logic [LblW-1:0] COUNT_MAX = 15'd16384;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RD_ITEM,
    RD_SCAN,
    RD_NBR
  } rdsel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QRD,
    ST_RCLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cell_x;
    logic [7:0] cell_z;
    logic       is_marked;
  } in_t;

  typedef struct packed {
    logic signed [LblW-1:0] label;
    logic [LblW-1:0]        section_count;
    logic                   out_of_grid;
  } out_t;

  typedef struct packed {
    logic   capture;
    logic   clr_mark;
    logic   clr_label;
    logic   mark_wr;
    rdsel_e rd_sel;
    logic   scan_init;
    logic   scan_next;
    logic   start_fill;
    logic   stk_pop;
    logic   cur_load;
    logic   nb_init;
    logic   nb_next;
    logic   nb_write;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_hit;
    logic scan_last;
    logic stk_empty;
    logic nb_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/gccl_ctrl.sv */
// controller state machine: clearing, scan, flood fill and result sequencing
module gccl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_func_i,
  input  gccl_pkg::sts_t  sts_i,
  output logic            in_stall_o,
  output gccl_pkg::cmd_t  cmd_o
);

  gccl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gccl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = gccl_pkg::RD_ITEM;
    in_stall_o = 1'b1;
    case (state_q)
      gccl_pkg::ST_CLEAR: begin
        cmd_o.clr_mark  = 1'b1;
        cmd_o.clr_label = 1'b1;
        if (sts_i.clr_done) state_d = gccl_pkg::ST_IDLE;
      end
      gccl_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_func_i)
            gccl_pkg::FUNC_LOAD:  state_d = gccl_pkg::ST_LOAD;
            gccl_pkg::FUNC_RUN:   state_d = gccl_pkg::ST_RCLR;
            gccl_pkg::FUNC_QUERY: state_d = gccl_pkg::ST_QRD;
            default:              state_d = gccl_pkg::ST_FIN;
          endcase
        end
      end
      gccl_pkg::ST_LOAD: begin
        cmd_o.mark_wr = 1'b1;
        state_d = gccl_pkg::ST_FIN;
      end
      gccl_pkg::ST_QRD: begin
        state_d = gccl_pkg::ST_FIN;
      end
      gccl_pkg::ST_RCLR: begin
        cmd_o.clr_label = 1'b1;
        cmd_o.scan_init = 1'b1;
        if (sts_i.clr_done) state_d = gccl_pkg::ST_SCAN_RD;
      end
      gccl_pkg::ST_SCAN_RD: begin
        cmd_o.rd_sel = gccl_pkg::RD_SCAN;
        state_d = gccl_pkg::ST_SCAN_CHK;
      end
      gccl_pkg::ST_SCAN_CHK: begin
        cmd_o.rd_sel = gccl_pkg::RD_SCAN;
        if (sts_i.scan_hit) begin
          cmd_o.start_fill = 1'b1;
          state_d = gccl_pkg::ST_POP;
        end else if (sts_i.scan_last) begin
          state_d = gccl_pkg::ST_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = gccl_pkg::ST_SCAN_RD;
        end
      end
      gccl_pkg::ST_POP: begin
        if (!sts_i.stk_empty) begin
          cmd_o.stk_pop = 1'b1;
          state_d = gccl_pkg::ST_POP_WAIT;
        end else if (sts_i.scan_last) begin
          state_d = gccl_pkg::ST_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = gccl_pkg::ST_SCAN_RD;
        end
      end
      gccl_pkg::ST_POP_WAIT: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.nb_init  = 1'b1;
        state_d = gccl_pkg::ST_NB_RD;
      end
      gccl_pkg::ST_NB_RD: begin
        cmd_o.rd_sel = gccl_pkg::RD_NBR;
        state_d = gccl_pkg::ST_NB_CHK;
      end
      gccl_pkg::ST_NB_CHK: begin
        cmd_o.rd_sel   = gccl_pkg::RD_NBR;
        cmd_o.nb_write = 1'b1;
        if (sts_i.nb_last) begin
          state_d = gccl_pkg::ST_POP;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = gccl_pkg::ST_NB_RD;
        end
      end
      gccl_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = gccl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gccl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/gccl_dpath.sv */
// datapath: config registers, mark/label/stack memories, scan and fill counters, output register
module gccl_dpath #(
  parameter int MAX_X = 256,
  parameter int MAX_Z = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gccl_pkg::CfgW-1:0] cfg_data_i,
  input  gccl_pkg::in_t             in_data_i,
  input  gccl_pkg::cmd_t            cmd_i,
  input  logic                      out_stall_i,
  output gccl_pkg::sts_t            sts_o,
  output logic                      out_valid_o,
  output gccl_pkg::out_t            out_data_o
);

  localparam int XW    = $clog2(MAX_X);
  localparam int ZW    = $clog2(MAX_Z);
  localparam int AW    = XW + ZW;
  localparam int Depth = 1 << AW;
  localparam int XCW   = $clog2(MAX_X + 1);
  localparam int ZCW   = $clog2(MAX_Z + 1);
  localparam int M1    = (XCW > ZCW) ? XCW : ZCW;
  localparam int CMPW  = ((M1 > gccl_pkg::CfgW) ? M1 : gccl_pkg::CfgW) + 1;
  localparam int LW    = gccl_pkg::LblW;

  // configuration
  logic [gccl_pkg::CfgW-1:0] width_q, depth_q;
  logic [CMPW-1:0] w_eff, d_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256;
      depth_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gccl_pkg::CFG_WIDTH) width_q <= cfg_data_i;
      if (cfg_idx_i == gccl_pkg::CFG_DEPTH) depth_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (width_q == '0) w_eff = CMPW'(1);
    else if (CMPW'(width_q) > CMPW'(MAX_X)) w_eff = CMPW'(MAX_X);
    else w_eff = CMPW'(width_q);
    if (depth_q == '0) d_eff = CMPW'(1);
    else if (CMPW'(depth_q) > CMPW'(MAX_Z)) d_eff = CMPW'(MAX_Z);
    else d_eff = CMPW'(depth_q);
  end

  // captured word
  gccl_pkg::in_t item_q;
  logic          in_grid;
  logic [AW-1:0] item_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  assign in_grid   = (CMPW'(item_q.cell_x) < w_eff) && (CMPW'(item_q.cell_z) < d_eff);
  assign item_addr = {ZW'(item_q.cell_z), XW'(item_q.cell_x)};

  // raster scan position
  logic [XW-1:0] sx_q;
  logic [ZW-1:0] sz_q;
  logic          sx_last, sz_last;
  logic [AW-1:0] scan_addr;

  assign sx_last   = (CMPW'(sx_q) + CMPW'(1'b1)) == w_eff;
  assign sz_last   = (CMPW'(sz_q) + CMPW'(1'b1)) == d_eff;
  assign scan_addr = {sz_q, sx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sx_q <= '0;
      sz_q <= '0;
    end else if (cmd_i.scan_next) begin
      if (sx_last) begin
        sx_q <= '0;
        sz_q <= sz_q + ZW'(1);
      end else begin
        sx_q <= sx_q + XW'(1);
      end
    end
  end

  // current fill cell and neighbor walk, offsets 0..2 stand for -1..+1
  logic [AW-1:0]   cur_q;
  logic [1:0]      dx_q, dz_q;
  logic [CMPW-1:0] sumx, sumz, nxw, nzw;
  logic            nb_ok;
  logic [AW-1:0]   nb_addr;

  assign sumx    = CMPW'(cur_q[XW-1:0]) + CMPW'(dx_q);
  assign sumz    = CMPW'(cur_q[AW-1:XW]) + CMPW'(dz_q);
  assign nxw     = sumx - CMPW'(1'b1);
  assign nzw     = sumz - CMPW'(1'b1);
  assign nb_ok   = (sumx != '0) && (sumx <= w_eff) && (sumz != '0) && (sumz <= d_eff);
  assign nb_addr = {nzw[ZW-1:0], nxw[XW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_init) begin
      dx_q <= '0;
      dz_q <= '0;
    end else if (cmd_i.nb_next) begin
      if (dz_q == 2'd2) begin
        dz_q <= '0;
        dx_q <= dx_q + 2'd1;
      end else begin
        dz_q <= dz_q + 2'd1;
      end
    end
  end

  // clearing sweep
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_label) clr_q <= clr_q + AW'(1);
  end

  // mark and label memories share one read address
  logic          mark_mem [Depth];
  logic [LW-1:0] label_mem [Depth];
  logic [AW-1:0] rd_addr;
  logic          mark_rd_q;
  logic [LW-1:0] label_rd_q;
  logic          mark_we, mark_wd;
  logic [AW-1:0] mark_wa;
  logic          lbl_we;
  logic [AW-1:0] lbl_wa;
  logic [LW-1:0] lbl_wd;
  logic [LW-1:0] cnt_q, cur_lab_q;
  logic          fresh, nb_hit;

  always_comb begin
    case (cmd_i.rd_sel)
      gccl_pkg::RD_SCAN: rd_addr = scan_addr;
      gccl_pkg::RD_NBR:  rd_addr = nb_addr;
      default:           rd_addr = item_addr;
    endcase
  end

  assign fresh  = mark_rd_q && (label_rd_q == gccl_pkg::NO_LABEL);
  assign nb_hit = cmd_i.nb_write && nb_ok && fresh;

  always_comb begin
    mark_we = 1'b0;
    mark_wa = clr_q;
    mark_wd = 1'b0;
    if (cmd_i.clr_mark) begin
      mark_we = 1'b1;
    end else if (cmd_i.mark_wr && in_grid) begin
      mark_we = 1'b1;
      mark_wa = item_addr;
      mark_wd = item_q.is_marked;
    end
    lbl_we = 1'b0;
    lbl_wa = clr_q;
    lbl_wd = gccl_pkg::NO_LABEL;
    if (cmd_i.clr_label) begin
      lbl_we = 1'b1;
    end else if (cmd_i.start_fill) begin
      lbl_we = 1'b1;
      lbl_wa = scan_addr;
      lbl_wd = (cnt_q > gccl_pkg::LABEL_MAX) ? gccl_pkg::LABEL_MAX : cnt_q;
    end else if (nb_hit) begin
      lbl_we = 1'b1;
      lbl_wa = nb_addr;
      lbl_wd = cur_lab_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lbl_we) label_mem[lbl_wa] <= lbl_wd;
    label_rd_q <= label_mem[rd_addr];
  end

  // section counter and label of the fill in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_init) begin
      cnt_q <= '0;
    end else if (cmd_i.start_fill && (cnt_q < gccl_pkg::COUNT_MAX)) begin
      cnt_q <= cnt_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_fill) cur_lab_q <= lbl_wd;
  end

  // fill stack
  logic [AW-1:0] stk_mem [Depth];
  logic [AW:0]   top_q, top_m1;
  logic [AW-1:0] stk_rd_q;
  logic          push;
  logic [AW-1:0] push_data;

  assign top_m1    = top_q - (AW+1)'(1);
  assign push      = cmd_i.start_fill || nb_hit;
  assign push_data = cmd_i.start_fill ? scan_addr : nb_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_q <= '0;
    else if (push) top_q <= top_q + (AW+1)'(1);
    else if (cmd_i.stk_pop) top_q <= top_m1;
  end

  always_ff @(posedge clk_i) begin
    if (push) stk_mem[top_q[AW-1:0]] <= push_data;
    if (cmd_i.stk_pop) stk_rd_q <= stk_mem[top_m1[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) cur_q <= stk_rd_q;
  end

  // output register
  logic           out_valid_q;
  gccl_pkg::out_t out_q, out_d;

  always_comb begin
    out_d.label         = gccl_pkg::NO_LABEL;
    out_d.section_count = cnt_q;
    out_d.out_of_grid   = 1'b0;
    case (item_q.func)
      gccl_pkg::FUNC_LOAD: begin
        out_d.out_of_grid = !in_grid;
      end
      gccl_pkg::FUNC_QUERY: begin
        out_d.out_of_grid = !in_grid;
        if (in_grid && mark_rd_q) out_d.label = label_rd_q;
      end
      default: begin
        out_d.out_of_grid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.clr_done  = &clr_q;
  assign sts_o.scan_hit  = fresh;
  assign sts_o.scan_last = sx_last && sz_last;
  assign sts_o.stk_empty = (top_q == '0);
  assign sts_o.nb_last   = (dx_q == 2'd2) && (dz_q == 2'd2);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

/* rtl/grid_connected_component_labeling.sv */
// top level of the grid connected component labeling block
// Labels 8-connected regions of marked cells. After reset the block clears its mark and
// label memories, one cell per cycle over all 2^(clog2(MAX_X)+clog2(MAX_Z)) cells (65536 at
// the defaults), and holds in_stall_o high meanwhile. One word is worked on at a time:
// a load or a query goes through ST_LOAD or ST_QRD to ST_FIN, which loads the output
// register (the unused code goes to ST_FIN at once), then back to ST_IDLE for the next word.
// A run first sweeps the whole label memory, then scans the configured grid cell by cell
// (ST_SCAN_RD, ST_SCAN_CHK), and for each labeled cell pops it (ST_POP, ST_POP_WAIT) and
// reads its 3x3 neighbors one at a time (ST_NB_RD, ST_NB_CHK) through the single read
// port of the cell memories; a fill closes in ST_POP once the stack is empty.
// A waiting result sits in the output register and the next word is taken meanwhile.
`include "assert_macros.svh"

module grid_connected_component_labeling #(
  parameter int MAX_X = 256,
  parameter int MAX_Z = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gccl_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  gccl_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gccl_pkg::out_t            out_data_o
);

  gccl_pkg::cmd_t cmd;
  gccl_pkg::sts_t sts;

  gccl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  gccl_dpath #(
    .MAX_X (MAX_X),
    .MAX_Z (MAX_Z)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `GCCL_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free)
  `GCCL_ASSERT_IMP(a_pop_nonempty, cmd.stk_pop, !sts.stk_empty)
  `GCCL_ASSERT_NEXT(a_one_word, in_valid_i && !in_stall_o, in_stall_o)

endmodule
